### src/aifo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aifo_pkg;

    localparam int WINDOW      = 32;
    localparam int QUEUE_DEPTH = 1024;

    localparam int RANK_W  = 31;
    localparam int HANDLE_W = 16;
    localparam int BYTES_W = 16;
    localparam int BUF_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int STAT_W  = 3;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int Q16_ONE = 65536;

    localparam logic [RANK_W-1:0] RANK_MARK = RANK_W'(100000001);

    localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

    localparam logic [STAT_W-1:0] ST_ADMIT = 3'd0;
    localparam logic [STAT_W-1:0] ST_QDROP = 3'd1;
    localparam logic [STAT_W-1:0] ST_ROOM  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_DEQ   = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd5;
    localparam logic [STAT_W-1:0] ST_PEEK  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADMIT_FRACTION = 2'd1;

    localparam logic [BUF_W-1:0]  BUF_RESET  = 32'd10485760;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 16'd6554;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT,
        S_MUL,
        S_DEC,
        S_RD
    } state_t;

    typedef struct packed {
        logic              wr;
        logic [RANK_W-1:0] rank;
    } win_ctl_t;

endpackage

`default_nettype wire

### src/aifo_rank_win.sv
`timescale 1ns / 1ps
`default_nettype none

module aifo_rank_win
    import aifo_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire win_ctl_t         ctl,
    output logic [CNT_W-1:0]      count
);

    logic [RANK_W-1:0] win_reg [WINDOW];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [RANK_W-1:0] rank_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        slot_next = (32'(slot_reg) >= WINDOW - 1) ? '0 : slot_reg + 1'b1;
    end

    always_comb
    begin
        count_next = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            count_next = count_next + CNT_W'(win_reg[i] < rank_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
            slot_reg  <= '0;
            rank_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (ctl.wr)
            begin
                win_reg[slot_reg] <= ctl.rank;
                slot_reg          <= slot_next;
                rank_reg          <= ctl.rank;
            end
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

### src/aifo_admission_fifo.sv
// AIFO admission-controlled packet FIFO.
// Request channel: in_valid / in_stall with req_type, pkt_handle, pkt_bytes,
// rank_value. Each request gives exactly one word on the result channel:
// out_valid / out_stall with status, out_handle, out_bytes, used_bytes.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects
// buffer_bytes (0) or admit_fraction (1); other indexes are ignored.
// Write configuration only while no request is outstanding.
// An enqueue runs through accept with rank window update, count of smaller
// ranks, multiply, and decide and write the queue memory.
// Dequeue, peek and unused codes go through accept and a read state: the
// queue memory read is registered. One request is in flight at a time; the
// next is accepted as soon as the result is in the output register.
// If the receiver stalls, the result stays in the output register and the
// block finishes at most one more request, holding it until the register
// frees up.
// Reset clears the rank window, occupancy, queue pointers and count and
// restores the register defaults; queue memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module aifo_admission_fifo
    import aifo_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [REQ_W-1:0]     req_type,
    input  wire logic [HANDLE_W-1:0]  pkt_handle,
    input  wire logic [BYTES_W-1:0]   pkt_bytes,
    input  wire logic [RANK_W-1:0]    rank_value,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [STAT_W-1:0]         status,
    output logic [HANDLE_W-1:0]       out_handle,
    output logic [BYTES_W-1:0]        out_bytes,
    output logic [BUF_W-1:0]          used_bytes,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BUF_W-1:0]     cfg_data
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int ECNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = HANDLE_W + BYTES_W;
    localparam int PROD_W  = BUF_W + FRAC_W;
    localparam int P1_W    = CNT_W + BUF_W;
    localparam int KC_W    = FRAC_W + 1;
    localparam int LHS_W   = P1_W + KC_W;

    state_t state_reg, state_next;

    logic [BUF_W-1:0]    buf_bytes_reg;
    logic [FRAC_W-1:0]   admit_frac_reg;

    logic [BUF_W-1:0]    occ_reg, occ_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [ECNT_W-1:0]   ecount_reg, ecount_next;

    logic [REQ_W-1:0]    req_reg, req_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;

    logic                free_reg, free_next;
    logic                over_reg, over_next;
    logic                room_reg, room_next;
    logic [BUF_W-1:0]    diff_reg, diff_next;
    logic [P1_W-1:0]     p1_reg, p1_next;
    logic [LHS_W-1:0]    rhs_reg, rhs_next;

    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic [BYTES_W-1:0]  out_bytes_reg, out_bytes_next;
    logic [BUF_W-1:0]    used_reg, used_next;

    logic [ENTRY_W-1:0]  queue_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic                mem_rd;
    logic                mem_wr;

    logic [CNT_W-1:0]    win_count;
    win_ctl_t            win_ctl;

    logic                out_free;
    logic [RANK_W-1:0]   rank_norm;
    logic [PROD_W-1:0]   afb;
    logic [KC_W-1:0]     kc;
    logic [LHS_W-1:0]    lhs;
    logic                qdrop;
    logic [BUF_W:0]      need;
    logic [HANDLE_W-1:0] rd_handle;
    logic [BYTES_W-1:0]  rd_bytes;

    aifo_rank_win u_win (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (win_ctl),
        .count (win_count)
    );

    assign rank_norm = (rank_value == RANK_MARK) ? RANK_W'(1) : rank_value;
    assign rd_handle = rd_data_reg[ENTRY_W-1:BYTES_W];
    assign rd_bytes  = rd_data_reg[BYTES_W-1:0];
    assign afb       = PROD_W'(admit_frac_reg) * PROD_W'(buf_bytes_reg);
    assign need      = (BUF_W+1)'(occ_reg) + (BUF_W+1)'(bytes_reg);
    assign kc        = KC_W'(Q16_ONE) - KC_W'(admit_frac_reg);
    assign lhs       = LHS_W'(p1_reg) * LHS_W'(kc);
    assign qdrop     = !free_reg && (over_reg || !(lhs < rhs_reg));
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        in_stall        = 1'b1;
        mem_rd          = 1'b0;
        mem_wr          = 1'b0;
        win_ctl.wr      = 1'b0;
        win_ctl.rank    = rank_norm;

        occ_next        = occ_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        ecount_next     = ecount_reg;
        req_next        = req_reg;
        handle_next     = handle_reg;
        bytes_next      = bytes_reg;
        free_next       = free_reg;
        over_next       = over_reg;
        room_next       = room_reg;
        diff_next       = diff_reg;
        p1_next         = p1_reg;
        rhs_next        = rhs_reg;

        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        out_handle_next = out_handle_reg;
        out_bytes_next  = out_bytes_reg;
        used_next       = used_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    req_next    = req_type;
                    handle_next = pkt_handle;
                    bytes_next  = pkt_bytes;
                    mem_rd      = 1'b1;
                    if (req_type == REQ_ENQ)
                    begin
                        win_ctl.wr = 1'b1;
                        state_next = S_CNT;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end

            S_CNT:
            begin
                free_next  = {occ_reg, 16'b0} < afb;
                over_next  = occ_reg >= buf_bytes_reg;
                room_next  = need > (BUF_W+1)'(buf_bytes_reg);
                diff_next  = buf_bytes_reg - occ_reg;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                p1_next    = P1_W'(win_count) * P1_W'(buf_bytes_reg);
                rhs_next   = LHS_W'(diff_reg) * LHS_W'(WINDOW * Q16_ONE);
                state_next = S_DEC;
            end

            S_DEC:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_handle_next = '0;
                    out_bytes_next  = '0;
                    if (qdrop)
                    begin
                        status_next = ST_QDROP;
                    end
                    else if (room_reg)
                    begin
                        status_next = ST_ROOM;
                    end
                    else if (32'(ecount_reg) >= QUEUE_DEPTH)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next = ST_ADMIT;
                        mem_wr      = 1'b1;
                        tail_next   = (32'(tail_reg) >= QUEUE_DEPTH - 1) ? '0
                                                                         : tail_reg + 1'b1;
                        ecount_next = ecount_reg + 1'b1;
                        occ_next    = need[BUF_W-1:0];
                    end
                    used_next  = mem_wr ? need[BUF_W-1:0] : occ_reg;
                    state_next = S_IDLE;
                end
            end

            S_RD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = ST_EMPTY;
                    out_handle_next = '0;
                    out_bytes_next  = '0;
                    used_next       = occ_reg;
                    if ((req_reg == REQ_DEQ || req_reg == REQ_PEEK) && ecount_reg != '0)
                    begin
                        out_handle_next = rd_handle;
                        out_bytes_next  = rd_bytes;
                        if (req_reg == REQ_DEQ)
                        begin
                            status_next = ST_DEQ;
                            head_next   = (32'(head_reg) >= QUEUE_DEPTH - 1) ? '0
                                                                             : head_reg + 1'b1;
                            ecount_next = ecount_reg - 1'b1;
                            occ_next    = (occ_reg >= BUF_W'(rd_bytes))
                                        ? occ_reg - BUF_W'(rd_bytes) : '0;
                            used_next   = occ_next;
                        end
                        else
                        begin
                            status_next = ST_PEEK;
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            queue_mem[tail_reg] <= {handle_reg, bytes_reg};
        end
        if (mem_rd)
        begin
            rd_data_reg <= queue_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            buf_bytes_reg  <= BUF_RESET;
            admit_frac_reg <= FRAC_RESET;
            occ_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            ecount_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            ecount_reg    <= ecount_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_BUFFER_BYTES:   buf_bytes_reg  <= cfg_data;
                    CFG_ADMIT_FRACTION: admit_frac_reg <= cfg_data[FRAC_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        handle_reg     <= handle_next;
        bytes_reg      <= bytes_next;
        free_reg       <= free_next;
        over_reg       <= over_next;
        room_reg       <= room_next;
        diff_reg       <= diff_next;
        p1_reg         <= p1_next;
        rhs_reg        <= rhs_next;
        status_reg     <= status_next;
        out_handle_reg <= out_handle_next;
        out_bytes_reg  <= out_bytes_next;
        used_reg       <= used_next;
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_handle = out_handle_reg;
    assign out_bytes  = out_bytes_reg;
    assign used_bytes = used_reg;

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import aifo_pkg::*;

    localparam logic [REQ_W-1:0]     REQ_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam logic [BUF_W-1:0]     BUF_MAX     = '1;
    localparam logic [FRAC_W-1:0]    FRAC_MAX    = '1;
    localparam logic [FRAC_W-1:0]    FRAC_HALF   = 16'd32768;
    localparam int                   MAX_SHOWN   = 10;

    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  nbytes;
        logic [RANK_W-1:0]   rank;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  nbytes;
        logic [BUF_W-1:0]    used;
    } answer_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  nbytes;
    } stored_pkt_t;

    typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_mode_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [REQ_W-1:0]     req_type   = '0;
    logic [HANDLE_W-1:0]  pkt_handle = '0;
    logic [BYTES_W-1:0]   pkt_bytes  = '0;
    logic [RANK_W-1:0]    rank_value = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [STAT_W-1:0]    status;
    logic [HANDLE_W-1:0]  out_handle;
    logic [BYTES_W-1:0]   out_bytes;
    logic [BUF_W-1:0]     used_bytes;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [BUF_W-1:0]     cfg_data   = '0;

    // shadow of the admission state
    logic [RANK_W-1:0] rank_hist [WINDOW] = '{default: '0};
    int unsigned       rank_ptr   = 0;
    logic [BUF_W-1:0]  fill_bytes = '0;
    stored_pkt_t       fifo_q [$];
    logic [BUF_W-1:0]  cap_bytes  = BUF_RESET;
    logic [FRAC_W-1:0] frac_q16   = FRAC_RESET;

    request_t request_q [$];
    answer_t  answer_q [$];
    int       n_fail = 0;

    aifo_admission_fifo u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .pkt_handle (pkt_handle),
        .pkt_bytes  (pkt_bytes),
        .rank_value (rank_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .out_handle (out_handle),
        .out_bytes  (out_bytes),
        .used_bytes (used_bytes),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic answer_t serve_request(request_t r);
        answer_t           a;
        logic [RANK_W-1:0] rk;
        int unsigned       smaller;
        logic [63:0]       b64;
        logic [63:0]       c64;
        logic [63:0]       lhs;
        logic [63:0]       rhs;
        logic [STAT_W-1:0] st;
        a = '0;
        a.status = ST_EMPTY;
        case (r.req)
            REQ_ENQ:
            begin
                rk = (r.rank == RANK_MARK) ? RANK_W'(1) : r.rank;
                rank_hist[rank_ptr] = rk;
                rank_ptr = (rank_ptr == WINDOW - 1) ? 0 : rank_ptr + 1;
                smaller = 0;
                for (int i = 0; i < WINDOW; i++)
                    if (rank_hist[i] < rk)
                        smaller++;
                b64 = 64'(cap_bytes);
                c64 = 64'(fill_bytes);
                st = ST_ADMIT;
                if (!(c64 * 64'(Q16_ONE) < 64'(frac_q16) * b64))
                begin
                    if (c64 >= b64)
                        st = ST_QDROP;
                    else
                    begin
                        lhs = 64'(smaller) * b64 * (64'(Q16_ONE) - 64'(frac_q16));
                        rhs = (b64 - c64) * 64'(WINDOW) * 64'(Q16_ONE);
                        if (!(lhs < rhs))
                            st = ST_QDROP;
                    end
                end
                if (st == ST_ADMIT)
                begin
                    if (c64 + 64'(r.nbytes) > b64)
                        st = ST_ROOM;
                    else if (fifo_q.size() >= QUEUE_DEPTH)
                        st = ST_FULL;
                    else
                    begin
                        fifo_q.insert(fifo_q.size(), {r.handle, r.nbytes});
                        fill_bytes = fill_bytes + BUF_W'(r.nbytes);
                    end
                end
                a.status = st;
            end
            REQ_DEQ, REQ_PEEK:
            begin
                if (fifo_q.size() > 0)
                begin
                    a.handle = fifo_q[0].handle;
                    a.nbytes = fifo_q[0].nbytes;
                    if (r.req == REQ_DEQ)
                    begin
                        fifo_q.delete(0);
                        fill_bytes = (fill_bytes >= BUF_W'(a.nbytes)) ?
                                     fill_bytes - BUF_W'(a.nbytes) : '0;
                        a.status = ST_DEQ;
                    end
                    else
                        a.status = ST_PEEK;
                end
            end
            default: ;
        endcase
        a.used = fill_bytes;
        return a;
    endfunction

    // request driver: bursts with random gaps
    int       burst_left = 0;
    int       gap_left   = 0;
    request_t next_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                answer_q.insert(answer_q.size(),
                                serve_request({req_type, pkt_handle, pkt_bytes,
                                               rank_value}));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    next_req = request_q[0];
                    request_q.delete(0);
                    req_type   <= next_req.req;
                    pkt_handle <= next_req.handle;
                    pkt_bytes  <= next_req.nbytes;
                    rank_value <= next_req.rank;
                    in_valid   <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor with its own stall pattern
    int          stall_run  = 0;
    stall_mode_t stall_mode = STALL_NONE;
    answer_t     got;
    answer_t     want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {status, out_handle, out_bytes, used_bytes};
                if (answer_q.size() == 0)
                begin
                    if (n_fail < MAX_SHOWN)
                        $display("unexpected word: status %0d handle %h bytes %0d used %0d",
                                 got.status, got.handle, got.nbytes, got.used);
                    n_fail++;
                end
                else
                begin
                    want = answer_q[0];
                    answer_q.delete(0);
                    if (got.status !== want.status || got.handle !== want.handle ||
                        got.nbytes !== want.nbytes || got.used !== want.used)
                    begin
                        if (n_fail < MAX_SHOWN)
                            $display("mismatch: exp %0d %h %0d %0d, got %0d %h %0d %0d",
                                     want.status, want.handle, want.nbytes, want.used,
                                     got.status, got.handle, got.nbytes, got.used);
                        n_fail++;
                    end
                end
            end
            if (stall_run == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(0, 2));
                stall_run  <= $urandom_range(4, 64);
            end
            else
                stall_run <= stall_run - 1;
            case (stall_mode)
                STALL_NONE: out_stall <= 1'b0;
                STALL_HALF: out_stall <= 1'($urandom_range(0, 1));
                default:    out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic put_req(logic [REQ_W-1:0] req, logic [HANDLE_W-1:0] handle,
                           logic [BYTES_W-1:0] nbytes, logic [RANK_W-1:0] rank);
        request_q.insert(request_q.size(), {req, handle, nbytes, rank});
    endtask

    task automatic random_phase(int n, int max_bytes, int enq_pct);
        request_t r;
        int       sub;
        for (int i = 0; i < n; i++)
        begin
            r.handle = HANDLE_W'($urandom);
            r.nbytes = BYTES_W'($urandom_range(0, max_bytes));
            if ($urandom_range(0, 99) < enq_pct)
                r.req = REQ_ENQ;
            else
            begin
                sub = $urandom_range(0, 19);
                r.req = (sub < 13) ? REQ_DEQ : (sub < 18) ? REQ_PEEK : REQ_UNUSED;
            end
            case ($urandom_range(0, 9))
                0:       r.rank = RANK_MARK;
                1:       r.rank = RANK_W'(1);
                2, 3:    r.rank = RANK_W'($urandom);
                default: r.rank = RANK_W'($urandom_range(0, 40));
            endcase
            request_q.insert(request_q.size(), r);
        end
    endtask

    // wait for the block to drain and every answer to be checked, then let the clock run on
    task automatic settle();
        do
            @(negedge clk);
        while (request_q.size() > 0 || in_valid || answer_q.size() > 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BUF_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BUFFER_BYTES:   cap_bytes = data;
            CFG_ADMIT_FRACTION: frac_q16 = data[FRAC_W-1:0];
            default: ;
        endcase
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue, unused code, field extremes, rank marker
        put_req(REQ_PEEK, '0, '0, '0);
        put_req(REQ_DEQ, '0, '0, '0);
        put_req(REQ_UNUSED, '1, '1, '1);
        put_req(REQ_ENQ, 16'hFFFF, 16'hFFFF, RANK_MARK);
        put_req(REQ_ENQ, 16'h0000, 16'h0000, '1);
        put_req(REQ_ENQ, 16'h1234, 16'h0001, '0);
        put_req(REQ_PEEK, '0, '0, '0);
        put_req(REQ_DEQ, '0, '0, '0);
        put_req(REQ_DEQ, '0, '0, '0);
        put_req(REQ_DEQ, '0, '0, '0);
        put_req(REQ_DEQ, '0, '0, '0);
        settle();

        // free region, quantile drop, no room, exact fit
        write_reg(CFG_BUFFER_BYTES, 32'd300);
        write_reg(CFG_ADMIT_FRACTION, {16'hA5C3, FRAC_HALF});
        write_reg(CFG_SPARE_2, 32'h5A5A_5A5A);
        write_reg(CFG_SPARE_3, 32'hFFFF_0001);
        put_req(REQ_ENQ, 16'h0101, 16'd100, 31'd5);
        put_req(REQ_ENQ, 16'h0202, 16'd40, 31'd50);
        put_req(REQ_ENQ, 16'h0303, 16'd20, 31'd9);
        put_req(REQ_ENQ, 16'h0404, 16'd10, '1);
        put_req(REQ_ENQ, 16'h0505, 16'd200, '0);
        put_req(REQ_ENQ, 16'h0606, 16'd140, 31'd3);
        settle();

        // capacity lowered below occupancy, then zero
        write_reg(CFG_BUFFER_BYTES, 32'd100);
        put_req(REQ_ENQ, 16'h0707, 16'd0, '0);
        settle();
        write_reg(CFG_BUFFER_BYTES, '0);
        put_req(REQ_ENQ, 16'h0808, 16'd1, 31'd7);
        put_req(REQ_DEQ, '0, '0, '0);
        put_req(REQ_PEEK, '0, '0, '0);
        settle();

        write_reg(CFG_BUFFER_BYTES, 32'd4000);
        write_reg(CFG_ADMIT_FRACTION, 32'(FRAC_HALF));
        random_phase(180, 600, 60);
        settle();

        write_reg(CFG_BUFFER_BYTES, 32'd1);
        write_reg(CFG_ADMIT_FRACTION, '0);
        random_phase(100, 2, 55);
        settle();

        write_reg(CFG_BUFFER_BYTES, BUF_MAX);
        random_phase(160, 65535, 55);
        settle();

        write_reg(CFG_BUFFER_BYTES, '0);
        write_reg(CFG_ADMIT_FRACTION, 32'(FRAC_MAX));
        random_phase(60, 65535, 40);
        settle();

        write_reg(CFG_BUFFER_BYTES, 32'd20000);
        write_reg(CFG_ADMIT_FRACTION, 32'(FRAC_RESET));
        random_phase(200, 4000, 60);
        settle();

        // enqueue-heavy run to fill the queue and hit queue full drops
        write_reg(CFG_BUFFER_BYTES, BUF_MAX);
        write_reg(CFG_ADMIT_FRACTION, 32'(FRAC_MAX));
        random_phase(1200, 300, 98);
        settle();

        if (n_fail == 0 && answer_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
